FILE: sv/multiplexed_frame_deframer_macros.svh
// Assertion helpers shared by the deframer modules.
`ifndef MULTIPLEXED_FRAME_DEFRAMER_MACROS_SVH
`define MULTIPLEXED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

FILE: sv/mfd_pkg.sv
package mfd_pkg;

   // Delivery cut-off per subpacket and number of addressable peripherals.
   localparam int MaxData        = 256;
   localparam int NumPeripherals = 16;

   // The enable mask is one 16-bit register.
   localparam int MaskWidth   = 16;
   localparam int PeriphLimit = (NumPeripherals < MaskWidth) ? NumPeripherals : MaskWidth;

   localparam logic [15:0] ChecksumKey      = 16'h5555;
   localparam logic [16:0] MaxDataWide      = 17'(MaxData);
   localparam logic [8:0]  PeriphLimitWide  = 9'(PeriphLimit);

   // Result queue between the parser and the output register.
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      PHASE_IDLE,
      PHASE_HEADER,
      PHASE_SUBHDR,
      PHASE_DATA,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_EMPTY,
      KIND_CHECKSUM_ERR,
      KIND_OVERRUN_ERR
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  peripheral_id;
      logic [7:0]  opcode;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: sv/mfd_channels.sv
interface mfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mfd_rsp_if import mfd_pkg::*; ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [3:0] peripheral_id;
   logic [7:0] opcode;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic       last;

   modport source (output valid, output kind, output peripheral_id, output opcode,
                   output data_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input kind, input peripheral_id, input opcode,
                   input data_byte, input byte_index, input last, output ready);
endinterface

interface mfd_cfg_if;
   logic        valid;
   logic        ready;
   logic [15:0] peripheral_enable_mask;

   modport source (output valid, output peripheral_enable_mask, input ready);
   modport sink   (input valid, input peripheral_enable_mask, output ready);
endinterface

FILE: sv/mfd_parser.sv
`include "multiplexed_frame_deframer_macros.svh"

module mfd_parser import mfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mfd_cfg_if.sink          csr_chan,
   mfd_req_if.sink          req_chan,
   input  queue_status_type queue_status,
   output push_type         push
);

   logic [MaskWidth-1:0] mask_ff;
   phase_type            phase_ff, phase_in;
   logic [1:0]           field_count_ff, field_count_in;
   logic [7:0]           size_low_ff, size_low_in;
   logic [7:0]           chk_low_ff, chk_low_in;
   logic [15:0]          frame_remaining_ff, frame_remaining_in;
   logic [15:0]          frame_size_ff, frame_size_in;
   logic [15:0]          sub_size_ff, sub_size_in;
   logic [15:0]          sub_count_ff, sub_count_in;
   logic [7:0]           periph_ff, periph_in;
   logic [7:0]           opcode_ff, opcode_in;

   logic        req_fire;
   logic [7:0]  rx_byte;
   logic [15:0] remaining_dec;
   logic [15:0] sub_size_full;
   logic [15:0] sub_count_inc;
   logic [16:0] index_next;
   logic        enabled;
   logic        deliver;
   logic        final_byte;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_status.full;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rx_byte        = req_chan.rx_byte;

   assign remaining_dec = frame_remaining_ff - 16'd1;
   assign sub_size_full = {rx_byte, sub_size_ff[7:0]};
   assign sub_count_inc = sub_count_ff + 16'd1;
   assign index_next    = {1'b0, sub_count_ff} + 17'd1;
   assign enabled       = ({1'b0, periph_ff} < PeriphLimitWide) && mask_ff[periph_ff[3:0]];
   assign deliver       = enabled && ({1'b0, sub_count_ff} < MaxDataWide);
   assign final_byte    = (index_next == {1'b0, sub_size_ff}) || (index_next == MaxDataWide);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff            <= '0;
         phase_ff           <= PHASE_IDLE;
         field_count_ff     <= '0;
         size_low_ff        <= '0;
         chk_low_ff         <= '0;
         frame_remaining_ff <= '0;
         frame_size_ff      <= '0;
         sub_size_ff        <= '0;
         sub_count_ff       <= '0;
         periph_ff          <= '0;
         opcode_ff          <= '0;
      end else begin
         if (csr_chan.valid) begin
            mask_ff <= csr_chan.peripheral_enable_mask;
         end
         phase_ff           <= phase_in;
         field_count_ff     <= field_count_in;
         size_low_ff        <= size_low_in;
         chk_low_ff         <= chk_low_in;
         frame_remaining_ff <= frame_remaining_in;
         frame_size_ff      <= frame_size_in;
         sub_size_ff        <= sub_size_in;
         sub_count_ff       <= sub_count_in;
         periph_ff          <= periph_in;
         opcode_ff          <= opcode_in;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      field_count_in     = field_count_ff;
      size_low_in        = size_low_ff;
      chk_low_in         = chk_low_ff;
      frame_remaining_in = frame_remaining_ff;
      frame_size_in      = frame_size_ff;
      sub_size_in        = sub_size_ff;
      sub_count_in       = sub_count_ff;
      periph_in          = periph_ff;
      opcode_in          = opcode_ff;
      push               = '0;

      if (req_fire) begin
         if (req_chan.frame_start) begin
            size_low_in    = rx_byte;
            field_count_in = 2'd1;
            phase_in       = PHASE_HEADER;
         end else begin
            unique case (phase_ff)
               PHASE_HEADER: begin
                  case (field_count_ff)
                     2'd1: begin
                        frame_size_in  = {rx_byte, size_low_ff};
                        field_count_in = 2'd2;
                     end
                     2'd2: begin
                        chk_low_in     = rx_byte;
                        field_count_in = 2'd3;
                     end
                     default: begin
                        field_count_in = 2'd0;
                        if (frame_size_ff == 16'd0) begin
                           phase_in = PHASE_DONE;
                        end else if ((frame_size_ff ^ ChecksumKey) != {rx_byte, chk_low_ff}) begin
                           phase_in           = PHASE_DONE;
                           push.valid         = 1'b1;
                           push.result.kind   = KIND_CHECKSUM_ERR;
                        end else begin
                           frame_remaining_in = frame_size_ff;
                           phase_in           = PHASE_SUBHDR;
                        end
                     end
                  endcase
               end
               PHASE_SUBHDR: begin
                  frame_remaining_in = remaining_dec;
                  case (field_count_ff)
                     2'd0:    periph_in   = rx_byte;
                     2'd1:    opcode_in   = rx_byte;
                     2'd2:    sub_size_in = {8'd0, rx_byte};
                     default: sub_size_in = sub_size_full;
                  endcase
                  if (field_count_ff != 2'd3) begin
                     field_count_in = field_count_ff + 2'd1;
                     // The subpacket header itself does not fit in the frame.
                     if (remaining_dec == 16'd0) begin
                        phase_in         = PHASE_DONE;
                        field_count_in   = 2'd0;
                        push.valid       = 1'b1;
                        push.result.kind = KIND_OVERRUN_ERR;
                     end
                  end else begin
                     field_count_in = 2'd0;
                     if (sub_size_full > remaining_dec) begin
                        phase_in         = PHASE_DONE;
                        push.valid       = 1'b1;
                        push.result.kind = KIND_OVERRUN_ERR;
                     end else begin
                        sub_count_in = 16'd0;
                        if (sub_size_full == 16'd0) begin
                           phase_in = (remaining_dec == 16'd0) ? PHASE_DONE : PHASE_SUBHDR;
                           if (enabled) begin
                              push.valid                = 1'b1;
                              push.result.kind          = KIND_EMPTY;
                              push.result.peripheral_id = periph_ff[3:0];
                              push.result.opcode        = opcode_ff;
                              push.result.last          = 1'b1;
                           end
                        end else begin
                           phase_in = PHASE_DATA;
                        end
                     end
                  end
               end
               PHASE_DATA: begin
                  frame_remaining_in = remaining_dec;
                  sub_count_in       = sub_count_inc;
                  if (sub_count_inc == sub_size_ff) begin
                     phase_in = (remaining_dec == 16'd0) ? PHASE_DONE : PHASE_SUBHDR;
                  end
                  if (deliver) begin
                     push.valid                = 1'b1;
                     push.result.kind          = KIND_PAYLOAD;
                     push.result.peripheral_id = periph_ff[3:0];
                     push.result.opcode        = opcode_ff;
                     push.result.data_byte     = rx_byte;
                     push.result.byte_index    = sub_count_ff[7:0];
                     push.result.last          = final_byte;
                  end
               end
               PHASE_IDLE, PHASE_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   `MFD_ASSERT_NOW(a_chk_err_at_header_end, clock, reset, push.valid && push.result.kind == KIND_CHECKSUM_ERR, phase_ff == PHASE_HEADER && field_count_ff == 2'd3)
   `MFD_ASSERT_NOW(a_done_is_silent, clock, reset, req_fire && !req_chan.frame_start && phase_ff == PHASE_DONE, !push.valid)
   `MFD_ASSERT_NEXT(a_error_closes_frame, clock, reset, push.valid && (push.result.kind == KIND_CHECKSUM_ERR || push.result.kind == KIND_OVERRUN_ERR), phase_ff == PHASE_DONE)
   `MFD_ASSERT_NOW(a_payload_in_data, clock, reset, push.valid && push.result.kind == KIND_PAYLOAD, phase_ff == PHASE_DATA && enabled)

endmodule

FILE: sv/mfd_queue.sv
`include "multiplexed_frame_deframer_macros.svh"

module mfd_queue import mfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output result_type       head,
   output queue_status_type status
);

   localparam logic [QueuePtrWidth-1:0]   LastSlot  = QueuePtrWidth'(QueueDepth - 1);
   localparam logic [QueueCountWidth-1:0] FullCount = QueueCountWidth'(QueueDepth);
   localparam logic [QueuePtrWidth-1:0]   PtrStep   = QueuePtrWidth'(1);
   localparam logic [QueueCountWidth-1:0] CountStep = QueueCountWidth'(1);

   result_type                   slots_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0]   count_ff, count_in;

   assign head             = slots_ff[rd_ptr_ff];
   assign status.full      = (count_ff == FullCount);
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrStep;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrStep;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + CountStep;
      end else if (pop && !push.valid) begin
         count_in = count_ff - CountStep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.result;
      end
   end

   `MFD_ASSERT_NOW(a_no_push_when_full, clock, reset, push.valid, !status.full)
   `MFD_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop, status.not_empty)
   `MFD_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= FullCount)

endmodule

FILE: sv/mfd_out_stage.sv
module mfd_out_stage import mfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  result_type       head,
   input  queue_status_type queue_status,
   output logic             pop,
   mfd_rsp_if.source        rsp_chan
);

   logic       valid_ff, valid_in;
   result_type result_ff;
   logic       load;

   // The register takes a new item whenever it is empty or being drained.
   assign load     = !valid_ff || rsp_chan.ready;
   assign pop      = load && queue_status.not_empty;
   assign valid_in = load ? queue_status.not_empty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= head;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = result_ff.kind;
   assign rsp_chan.peripheral_id = result_ff.peripheral_id;
   assign rsp_chan.opcode        = result_ff.opcode;
   assign rsp_chan.data_byte     = result_ff.data_byte;
   assign rsp_chan.byte_index    = result_ff.byte_index;
   assign rsp_chan.last          = result_ff.last;

endmodule

FILE: sv/multiplexed_frame_deframer.sv
// Multiplexed frame deframer: turns a stream of received link bytes into tagged
// payload items for up to 16 peripherals.
// The req channel carries one received byte per item, with frame_start marking the
// first header byte of a transaction. The rsp channel carries at most one item per
// accepted byte: a payload byte, an empty-subpacket marker, a header checksum error
// or a length overrun error. The csr channel writes the 16-bit peripheral enable
// mask; it is always ready and should be written only while the block is idle.
// Throughput is one byte per clock cycle while the queue is not full: the byte-wide
// parser finishes each byte in the cycle it is accepted and writes any result into
// a four-entry queue. From there a result is loaded into the registered output
// stage, which presents it on rsp until the receiver takes it.
// If the receiver stalls, results pile up in the queue and the output register; req
// ready drops only once the queue is full, and no result is ever lost.
// Reset is synchronous and clears the enable mask, the parser (back to waiting for a
// frame start), the queue and the output register. There is no clearing pass.

module multiplexed_frame_deframer import mfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mfd_cfg_if.sink   csr_chan,
   mfd_req_if.sink   req_chan,
   mfd_rsp_if.source rsp_chan
);

   push_type         push;
   queue_status_type queue_status;
   result_type       queue_head;
   logic             queue_pop;

   // Front: header and subpacket parsing, one byte per cycle while the queue has room.
   mfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_chan     (csr_chan),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push         (push)
   );

   // Decouples the parser from a stalling receiver.
   mfd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (queue_pop),
      .head   (queue_head),
      .status (queue_status)
   );

   // Back: registered result presentation.
   mfd_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .head         (queue_head),
      .queue_status (queue_status),
      .pop          (queue_pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

FILE: dv/tb.sv
// Self-checking bench for multiplexed_frame_deframer.

module tb;
   import mfd_pkg::*;

   // How a row of the directed list is checked.
   typedef enum logic [1:0] {
      ROW_FROM_MODEL,
      ROW_NO_RESULT,
      ROW_GIVEN
   } row_mode_type;

   // Ways a random frame is spoiled on purpose.
   typedef enum logic [2:0] {
      FLAW_NONE,
      FLAW_SHORT_SIZE,
      FLAW_BAD_CHECKSUM,
      FLAW_ZERO_SIZE,
      FLAW_TRUNCATED,
      FLAW_RANDOM_HEADER,
      FLAW_LARGE_SIZE
   } frame_flaw_type;

   typedef struct {
      logic [7:0]   value;
      logic         first;
      row_mode_type mode;
      result_type   want;
   } stim_row_type;

   localparam int NumRandomPhases = 6;
   localparam int PhaseBytes      = 75;
   localparam int SettleCycles    = 6;

   logic clock;
   logic reset;

   mfd_req_if req_if ();
   mfd_rsp_if rsp_if ();
   mfd_cfg_if csr_if ();

   multiplexed_frame_deframer DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_if),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // The bench keeps its own copy of the parser state and the enable mask. Every
   // accepted byte is pushed through it, and unless a directed row says otherwise,
   // whatever result it produces is queued as the next item the rsp channel owes us.
   logic [15:0] enable_mask;
   phase_type   parse_phase;
   logic [1:0]  field_cnt;
   logic [7:0]  size_lo;
   logic [7:0]  chk_lo;
   logic [15:0] frame_left;
   logic [15:0] frame_len;
   logic [15:0] sub_len;
   logic [15:0] sub_pos;
   logic [7:0]  cur_periph;
   logic [7:0]  cur_opcode;

   result_type   pending_results[$];
   stim_row_type directed_rows[$];

   int  bytes_sent;
   int  frames_sent;
   int  results_seen;
   int  mismatch_count;
   int  stall_left;
   bit  sender_gaps;
   bit  receiver_stalls;
   bit  quiet_tail;

   always #5 clock = ~clock;

   function automatic result_type pack_result(input kind_type k, input logic [3:0] periph,
                                              input logic [7:0] op, input logic [7:0] data,
                                              input logic [7:0] idx, input logic fin);
      result_type r;
      r.kind          = k;
      r.peripheral_id = periph;
      r.opcode        = op;
      r.data_byte     = data;
      r.byte_index    = idx;
      r.last          = fin;
      return r;
   endfunction

   // A subpacket reaches its handler only for ids the mask can address and enables.
   function automatic bit periph_enabled();
      return int'(cur_periph) < PeriphLimit && enable_mask[cur_periph[3:0]];
   endfunction

   // One byte through the parser: updates the local state and tells whether the
   // byte produces a result, and which one.
   task automatic deframe_byte(input logic [7:0] b, input logic first,
                               output bit got, output result_type r);
      logic [15:0] pos;
      bit          deliver;
      bit          fin;
      got = 1'b0;
      r   = '0;
      if (first) begin
         // A frame start always opens a new header, dropping any frame in flight.
         size_lo     = b;
         field_cnt   = 2'd1;
         parse_phase = PHASE_HEADER;
      end else begin
         case (parse_phase)
            PHASE_HEADER: begin
               if (field_cnt == 2'd1) begin
                  frame_len = {b, size_lo};
                  field_cnt = 2'd2;
               end else if (field_cnt == 2'd2) begin
                  chk_lo    = b;
                  field_cnt = 2'd3;
               end else begin
                  field_cnt = 2'd0;
                  if (frame_len == 16'd0) begin
                     parse_phase = PHASE_DONE;
                  end else if ((frame_len ^ ChecksumKey) != {b, chk_lo}) begin
                     parse_phase = PHASE_DONE;
                     got = 1'b1;
                     r   = pack_result(KIND_CHECKSUM_ERR, '0, '0, '0, '0, 1'b0);
                  end else begin
                     frame_left  = frame_len;
                     parse_phase = PHASE_SUBHDR;
                  end
               end
            end
            PHASE_SUBHDR: begin
               frame_left = frame_left - 16'd1;
               case (field_cnt)
                  2'd0:    cur_periph = b;
                  2'd1:    cur_opcode = b;
                  2'd2:    sub_len    = {8'd0, b};
                  default: sub_len    = {b, sub_len[7:0]};
               endcase
               if (field_cnt < 2'd3) begin
                  field_cnt = field_cnt + 2'd1;
                  // The subpacket header itself does not fit in the frame.
                  if (frame_left == 16'd0) begin
                     parse_phase = PHASE_DONE;
                     field_cnt   = 2'd0;
                     got = 1'b1;
                     r   = pack_result(KIND_OVERRUN_ERR, '0, '0, '0, '0, 1'b0);
                  end
               end else begin
                  field_cnt = 2'd0;
                  if (sub_len > frame_left) begin
                     parse_phase = PHASE_DONE;
                     got = 1'b1;
                     r   = pack_result(KIND_OVERRUN_ERR, '0, '0, '0, '0, 1'b0);
                  end else begin
                     sub_pos = 16'd0;
                     if (sub_len == 16'd0) begin
                        parse_phase = (frame_left == 16'd0) ? PHASE_DONE : PHASE_SUBHDR;
                        if (periph_enabled()) begin
                           got = 1'b1;
                           r   = pack_result(KIND_EMPTY, cur_periph[3:0], cur_opcode,
                                             '0, '0, 1'b1);
                        end
                     end else begin
                        parse_phase = PHASE_DATA;
                     end
                  end
               end
            end
            PHASE_DATA: begin
               pos        = sub_pos;
               deliver    = periph_enabled() && int'(pos) < MaxData;
               fin        = (int'(pos) + 1 == int'(sub_len)) || (int'(pos) + 1 == MaxData);
               frame_left = frame_left - 16'd1;
               sub_pos    = sub_pos + 16'd1;
               if (sub_pos == sub_len)
                  parse_phase = (frame_left == 16'd0) ? PHASE_DONE : PHASE_SUBHDR;
               if (deliver) begin
                  got = 1'b1;
                  r   = pack_result(KIND_PAYLOAD, cur_periph[3:0], cur_opcode, b,
                                    pos[7:0], fin);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected kind=%0d periph=%h op=%h data=%h idx=%h last=%b, got kind=%0d periph=%h op=%h data=%h idx=%h last=%b",
                  $time, what, want.kind, want.peripheral_id, want.opcode, want.data_byte,
                  want.byte_index, want.last, seen.kind, seen.peripheral_id, seen.opcode,
                  seen.data_byte, seen.byte_index, seen.last);
   endtask

   // Called at a falling edge. Drives one byte, holds it until the block takes it,
   // then records what the block owes for it and returns at the next falling edge.
   // A random gap may come first, while idling is allowed.
   task automatic push_byte(input logic [7:0] value, input logic first,
                            input row_mode_type mode, input result_type want);
      bit         got;
      result_type predicted;
      if (sender_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.rx_byte     <= value;
      req_if.frame_start <= first;
      do @(posedge clock); while (!req_if.ready);
      deframe_byte(value, first, got, predicted);
      case (mode)
         ROW_FROM_MODEL: if (got) pending_results.push_back(predicted);
         ROW_GIVEN:      pending_results.push_back(want);
         default:        ;
      endcase
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stop sending and let every owed result come out. A byte that causes no result
   // may still be inside the block, so a few more cycles pass on top.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_mask(input logic [15:0] mask);
      csr_if.valid                  <= 1'b1;
      csr_if.peripheral_enable_mask <= mask;
      do @(posedge clock); while (!csr_if.ready);
      enable_mask = mask;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic void add_row(input logic [7:0] value, input logic first,
                                   input row_mode_type mode, input result_type want);
      stim_row_type row;
      row.value = value;
      row.first = first;
      row.mode  = mode;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // A random frame: one to four subpackets, mostly small ones, sometimes empty, and
   // now and then an id past the peripheral range. About one frame in three is
   // spoiled in the header or cut short, and some get trailing bytes after the end.
   // The oversize variant carries one subpacket longer than the delivery cut-off.
   task automatic send_random_frame(input bit oversize);
      logic [7:0]     body[$];
      logic [7:0]     periph;
      logic [15:0]    size_field;
      logic [15:0]    chk_field;
      int             n_sub;
      int             len;
      int             cut;
      int             pick;
      frame_flaw_type flaw;
      n_sub = oversize ? 1 : $urandom_range(1, 4);
      for (int k = 0; k < n_sub; k++) begin
         periph = (oversize || $urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom_range(0, 255));
         if (oversize)
            len = $urandom_range(MaxData + 1, MaxData + 44);
         else if ($urandom_range(0, 5) == 0)
            len = 0;
         else
            len = $urandom_range(1, 10);
         body.push_back(periph);
         body.push_back(8'($urandom));
         body.push_back(8'(len));
         body.push_back(8'(len >> 8));
         repeat (len) body.push_back(8'($urandom));
      end
      size_field = 16'(body.size());
      chk_field  = size_field ^ ChecksumKey;
      pick = $urandom_range(0, 19);
      flaw = (oversize || pick > 5) ? FLAW_NONE : frame_flaw_type'(pick + 1);
      case (flaw)
         FLAW_SHORT_SIZE: begin
            size_field = 16'($urandom_range(1, body.size()));
            chk_field  = size_field ^ ChecksumKey;
         end
         FLAW_BAD_CHECKSUM: chk_field = chk_field ^ (16'd1 << $urandom_range(0, 15));
         FLAW_ZERO_SIZE: begin
            size_field = 16'd0;
            chk_field  = 16'($urandom);
         end
         FLAW_TRUNCATED: begin
            cut = $urandom_range(0, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
         end
         FLAW_RANDOM_HEADER: begin
            size_field = 16'($urandom);
            chk_field  = 16'($urandom);
         end
         FLAW_LARGE_SIZE: begin
            size_field = 16'($urandom);
            chk_field  = size_field ^ ChecksumKey;
         end
         default: ;
      endcase
      push_byte(size_field[7:0], 1'b1, ROW_FROM_MODEL, '0);
      push_byte(size_field[15:8], 1'b0, ROW_FROM_MODEL, '0);
      push_byte(chk_field[7:0], 1'b0, ROW_FROM_MODEL, '0);
      push_byte(chk_field[15:8], 1'b0, ROW_FROM_MODEL, '0);
      foreach (body[i]) push_byte(body[i], 1'b0, ROW_FROM_MODEL, '0);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, ROW_FROM_MODEL, '0);
      frames_sent++;
   endtask

   // Receiver side: ready drops for random bursts while stalls are allowed.
   always @(negedge clock) begin
      if (stall_left != 0 && !quiet_tail) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (receiver_stalls && !quiet_tail && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Every item taken from the rsp channel is matched against the oldest result
   // still owed, field by field.
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = pack_result(rsp_if.kind, rsp_if.peripheral_id, rsp_if.opcode,
                            rsp_if.data_byte, rsp_if.byte_index, rsp_if.last);
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, seen);
         end else begin
            want = pending_results.pop_front();
            if (seen.kind !== want.kind || seen.peripheral_id !== want.peripheral_id ||
                seen.opcode !== want.opcode || seen.data_byte !== want.data_byte ||
                seen.byte_index !== want.byte_index || seen.last !== want.last)
               report_mismatch("result mismatch", want, seen);
         end
      end
   end

   // Hard stop in case the block hangs somewhere.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] mask_plan[NumRandomPhases];
      int          phase_start;
      clock                         = 1'b0;
      reset                         = 1'b1;
      req_if.valid                  = 1'b0;
      req_if.rx_byte                = 8'd0;
      req_if.frame_start            = 1'b0;
      rsp_if.ready                  = 1'b0;
      csr_if.valid                  = 1'b0;
      csr_if.peripheral_enable_mask = 16'd0;
      enable_mask                   = 16'd0;
      parse_phase                   = PHASE_IDLE;
      field_cnt                     = 2'd0;
      size_lo                       = 8'd0;
      chk_lo                        = 8'd0;
      frame_left                    = 16'd0;
      frame_len                     = 16'd0;
      sub_len                       = 16'd0;
      sub_pos                       = 16'd0;
      cur_periph                    = 8'd0;
      cur_opcode                    = 8'd0;
      bytes_sent                    = 0;
      frames_sent                   = 0;
      results_seen                  = 0;
      mismatch_count                = 0;
      stall_left                    = 0;
      sender_gaps                   = 1'b1;
      receiver_stalls               = 1'b1;
      quiet_tail                    = 1'b0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed list, run with every peripheral enabled.
      // A stray byte before any frame start is dropped.
      add_row(8'hFF, 1'b0, ROW_NO_RESULT, '0);
      // Five-byte frame carrying one subpacket with a single data byte for
      // peripheral 3, opcode 0xFF.
      add_row(8'h05, 1'b1, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h50, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h55, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h03, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'hFF, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h01, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h80, 1'b0, ROW_GIVEN,
              pack_result(KIND_PAYLOAD, 4'h3, 8'hFF, 8'h80, 8'h00, 1'b1));
      // Size one with a zero checksum is rejected at the last header byte.
      add_row(8'h01, 1'b1, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_GIVEN,
              pack_result(KIND_CHECKSUM_ERR, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
      // A zero-size frame carries nothing, whatever its checksum says.
      add_row(8'h00, 1'b1, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_NO_RESULT, '0);
      // An empty subpacket for peripheral 15 gives a marker, and the one byte left
      // in the frame cannot hold the next subpacket header.
      add_row(8'h05, 1'b1, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h50, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h55, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h0F, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_FROM_MODEL, '0);
      add_row(8'h00, 1'b0, ROW_GIVEN,
              pack_result(KIND_EMPTY, 4'hF, 8'h00, 8'h00, 8'h00, 1'b1));
      add_row(8'hFF, 1'b0, ROW_GIVEN,
              pack_result(KIND_OVERRUN_ERR, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));

      write_mask(16'hFFFF);
      foreach (directed_rows[i])
         push_byte(directed_rows[i].value, directed_rows[i].first, directed_rows[i].mode,
                   directed_rows[i].want);

      // Random phases, each under its own enable mask and idling pattern. The mask
      // is only rewritten once the block has gone quiet, which also gives the
      // sender a full pause at every phase boundary. Phase 2 runs without any
      // idling, and the last phase is the quiet tail with every peripheral on.
      mask_plan[0] = 16'hFFFF;
      mask_plan[1] = 16'h0000;
      mask_plan[2] = 16'($urandom);
      mask_plan[3] = 16'h8001;
      mask_plan[4] = 16'($urandom);
      mask_plan[5] = 16'hFFFF;
      for (int p = 0; p < NumRandomPhases; p++) begin
         drain_results();
         sender_gaps     = (p != 2) && (p != 3);
         receiver_stalls = (p != 2);
         quiet_tail      = (p == NumRandomPhases - 1);
         write_mask(mask_plan[p]);
         // One subpacket past the delivery cut-off, early in the first phase.
         if (p == 0)
            send_random_frame(1'b1);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            if ($urandom_range(0, 11) == 0)
               repeat ($urandom_range(1, 4))
                  push_byte(8'($urandom), 1'($urandom_range(0, 1)), ROW_FROM_MODEL, '0);
            else
               send_random_frame(1'b0);
         end
      end

      drain_results();
      if (pending_results.size() != 0)
         mismatch_count += pending_results.size();

      $display("Sent %0d bytes in %0d random frames plus directed rows; checked %0d results.",
               bytes_sent, frames_sent, results_seen);
      $display("Enable mask took %0d settings; %0d mismatches.", NumRandomPhases + 1,
               mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
